@@ rtl/core/twdp_pkg.sv @@
// Shared types and constants for the ternary weight dot product.
`default_nettype none

package twdp_pkg;

  // Fixed datapath sizes.
  localparam int LANES     = 4;
  localparam int ACT_WIDTH = 16;
  localparam int ACC_WIDTH = 32;
  localparam int WT_WIDTH  = 2;
  localparam int CNT_WIDTH = 3;

  // One lane sum can reach LANES times the largest activation magnitude.
  localparam int SUM_WIDTH = ACT_WIDTH + $clog2(LANES) + 1;

  // Weight codes that contribute; every other code contributes nothing.
  localparam logic [WT_WIDTH-1:0] WT_POS = 2'b01;
  localparam logic [WT_WIDTH-1:0] WT_NEG = 2'b11;

  // Accumulator limits.
  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  typedef logic signed [ACT_WIDTH-1:0] act_t;
  typedef logic [WT_WIDTH-1:0]         wt_t;
  typedef logic [CNT_WIDTH-1:0]        cnt_t;
  typedef logic signed [SUM_WIDTH-1:0] lane_sum_t;
  typedef logic signed [ACC_WIDTH-1:0] acc_t;

endpackage

`default_nettype wire

@@ rtl/core/twdp_if.sv @@
// Valid/ready channel interfaces for the input and result beats.
`default_nettype none

interface twdp_in_if;
  import twdp_pkg::*;

  logic                           valid;
  logic                           ready;
  logic signed [ACT_WIDTH-1:0]    act0;
  logic signed [ACT_WIDTH-1:0]    act1;
  logic signed [ACT_WIDTH-1:0]    act2;
  logic signed [ACT_WIDTH-1:0]    act3;
  logic signed [WT_WIDTH-1:0]     wt0;
  logic signed [WT_WIDTH-1:0]     wt1;
  logic signed [WT_WIDTH-1:0]     wt2;
  logic signed [WT_WIDTH-1:0]     wt3;
  logic        [CNT_WIDTH-1:0]    valid_lanes;
  logic                           last_item;

  modport source (
    output valid, act0, act1, act2, act3, wt0, wt1, wt2, wt3, valid_lanes, last_item,
    input  ready
  );
  modport sink (
    input  valid, act0, act1, act2, act3, wt0, wt1, wt2, wt3, valid_lanes, last_item,
    output ready
  );
endinterface

interface twdp_out_if;
  import twdp_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [ACC_WIDTH-1:0] dot_sum;
  logic                        saturated;

  modport source (output valid, dot_sum, saturated, input ready);
  modport sink   (input valid, dot_sum, saturated, output ready);
endinterface

`default_nettype wire

@@ rtl/core/twdp_lane_sum.sv @@
// Combinational signed sum of the enabled lanes of one input beat.
`default_nettype none

module twdp_lane_sum (
  input  twdp_pkg::act_t      act [twdp_pkg::LANES],
  input  twdp_pkg::wt_t       wt  [twdp_pkg::LANES],
  input  twdp_pkg::cnt_t      valid_lanes,
  output twdp_pkg::lane_sum_t sum
);
  import twdp_pkg::*;

  // Each leading lane adds, subtracts or skips its activation.
  // A lane count above LANES simply enables every lane.
  always_comb begin
    lane_sum_t ext;
    sum = '0;
    for (int i = 0; i < LANES; i++) begin
      ext = {{(SUM_WIDTH-ACT_WIDTH){act[i][ACT_WIDTH-1]}}, act[i]};
      if (valid_lanes > CNT_WIDTH'(i)) begin
        case (wt[i])
          WT_POS:  sum = sum + ext;
          WT_NEG:  sum = sum - ext;
          default: sum = sum;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ternary_weight_dot_product.sv @@
// Top level: multiply-free dot product of Q8.8 activations with ternary weights.
//
// Usage: each input beat on in_ch carries four signed Q8.8 activations, four
// two-bit weights (+1 adds, -1 subtracts, 0 and the unused code skip), a count
// of leading lanes that take part, and a last flag. Lane sums accumulate into a
// 32-bit saturating accumulator. A beat with last_item set produces one result
// beat on out_ch: the Q24.8 sum including that beat, plus a flag that is set if
// the accumulator clipped anywhere in the run; the run state then clears.
// A last beat passes from the input register to the result register on out_ch.
// Throughput: one input beat per cycle while no last beat waits on a stalled
// out_ch, set by the single accumulate-and-saturate step between the two
// registers. Non-last beats never wait on out_ch. When out_ch stalls with a
// result pending, a new last beat stays in the input register and in_ch.ready
// drops until the result is taken. Synchronous reset clears the accumulator,
// the clip flag and all valid flags; no beat is pending after reset.
`default_nettype none

module ternary_weight_dot_product (
  input  wire          clk,
  input  wire          rst,
  twdp_in_if.sink      in_ch,
  twdp_out_if.source   out_ch
);
  import twdp_pkg::*;

  // Input register.
  logic      s1_valid;
  act_t      s1_act [LANES];
  wt_t       s1_wt  [LANES];
  cnt_t      s1_lanes;
  logic      s1_last;

  // Run state and result register.
  acc_t      acc;
  logic      clip_seen;
  logic      out_valid;
  acc_t      out_sum;
  logic      out_sat;

  lane_sum_t lane_sum;
  logic signed [ACC_WIDTH:0] wide_sum;
  acc_t      acc_next;
  logic      clip_now;
  logic      out_free;
  logic      s1_go;
  logic      in_take;

  // Handshake: only a last beat needs room in the result register.
  assign out_free = !out_valid || out_ch.ready;
  assign s1_go    = s1_valid && (!s1_last || out_free);
  assign in_take  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !s1_valid || s1_go;

  // Capture an input beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
    if (in_take) begin
      s1_act[0] <= in_ch.act0;
      s1_act[1] <= in_ch.act1;
      s1_act[2] <= in_ch.act2;
      s1_act[3] <= in_ch.act3;
      s1_wt[0]  <= in_ch.wt0;
      s1_wt[1]  <= in_ch.wt1;
      s1_wt[2]  <= in_ch.wt2;
      s1_wt[3]  <= in_ch.wt3;
      s1_lanes  <= in_ch.valid_lanes;
      s1_last   <= in_ch.last_item;
    end
  end

  twdp_lane_sum u_lane_sum (
    .act         (s1_act),
    .wt          (s1_wt),
    .valid_lanes (s1_lanes),
    .sum         (lane_sum)
  );

  // Add one guard bit and clip to the accumulator range.
  always_comb begin
    wide_sum = {acc[ACC_WIDTH-1], acc}
             + {{(ACC_WIDTH+1-SUM_WIDTH){lane_sum[SUM_WIDTH-1]}}, lane_sum};
    clip_now = wide_sum[ACC_WIDTH] != wide_sum[ACC_WIDTH-1];
    if (!clip_now) begin
      acc_next = wide_sum[ACC_WIDTH-1:0];
    end else if (wide_sum[ACC_WIDTH]) begin
      acc_next = ACC_MIN;
    end else begin
      acc_next = ACC_MAX;
    end
  end

  // Accumulate, and on a last beat load the result and clear the run.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      clip_seen <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_go) begin
        if (s1_last) begin
          acc       <= '0;
          clip_seen <= 1'b0;
        end else begin
          acc       <= acc_next;
          clip_seen <= clip_seen || clip_now;
        end
      end
      if (s1_go && s1_last) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (s1_go && s1_last) begin
      out_sum <= acc_next;
      out_sat <= clip_seen || clip_now;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.dot_sum   = out_sum;
  assign out_ch.saturated = out_sat;

  // A finished run always leaves a cleared accumulator and clip flag.
  a_run_clears: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_last |=> acc == '0 && !clip_seen)
    else $error("run state not cleared after last beat");

  // A last beat leaving the input register always yields a pending result.
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_last |=> out_valid)
    else $error("last beat did not produce a result");

  // A held input beat blocks new input.
  a_hold_blocks: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |-> !in_ch.ready)
    else $error("input accepted over a held beat");

  // The clip flag is sticky within a run.
  a_clip_sticky: assert property (@(posedge clk) disable iff (rst)
    clip_seen && !(s1_go && s1_last) |=> clip_seen)
    else $error("clip flag dropped inside a run");

  // A non-last beat never waits on the result channel.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_last |-> s1_go)
    else $error("non-last beat stalled");

endmodule

`default_nettype wire

@@ tb/ternary_weight_dot_product_tb.sv @@
// Self-checking testbench for the ternary weight dot product: directed table, then random runs.
`default_nettype none

module ternary_weight_dot_product_tb;
  import twdp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Run lengths and the watchdog limit.
  localparam int RANDOM_ITEMS = 1528;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam int DIR_ROWS     = 22;

  // Weight codes that the package leaves unnamed, and activation extremes.
  localparam wt_t  WT_ZERO = 2'b00;
  localparam wt_t  WT_SKIP = 2'b10;
  localparam act_t ACT_MAX = 16'sh7FFF;
  localparam act_t ACT_MIN = 16'sh8000;

  // Where the expected result of a table row comes from.
  typedef enum logic {BY_MODEL, BY_TABLE} exp_src_t;

  typedef struct packed {
    act_t [LANES-1:0] act;
    wt_t  [LANES-1:0] wt;
    cnt_t             lanes;
    logic             last;
  } lane_group_t;

  typedef struct packed {
    acc_t dot_sum;
    logic saturated;
  } dot_result_t;

  typedef struct packed {
    lane_group_t grp;
    exp_src_t    src;
    acc_t        want_sum;
    logic        want_sat;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  twdp_in_if  in_ch ();
  twdp_out_if out_ch ();

  ternary_weight_dot_product uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predicted run state and the sums still owed by the block.
  acc_t        run_sum;
  logic        run_clip;
  dot_result_t expected_sums[$];
  int          mismatches;
  bit          src_idle_on;
  dir_row_t    dir_table [DIR_ROWS];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Prints one line per mismatch, up to a cap, and counts all of them.
  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 100) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
  endtask

  // Adds one lane group into the predicted accumulator; returns 1 when a sum is emitted.
  function automatic logic accumulate_group(input lane_group_t g, output dot_result_t r);
    longint total;
    longint next_sum;
    int     used;
    total = 0;
    used = (g.lanes > LANES) ? LANES : int'(g.lanes);
    for (int i = 0; i < used; i++) begin
      if (g.wt[i] == WT_POS) begin
        total += longint'($signed(g.act[i]));
      end else if (g.wt[i] == WT_NEG) begin
        total -= longint'($signed(g.act[i]));
      end
    end
    next_sum = longint'(run_sum) + total;
    if (next_sum > longint'(ACC_MAX)) begin
      next_sum = ACC_MAX;
      run_clip = 1'b1;
    end else if (next_sum < longint'(ACC_MIN)) begin
      next_sum = ACC_MIN;
      run_clip = 1'b1;
    end
    run_sum = acc_t'(next_sum);
    r.dot_sum = run_sum;
    r.saturated = run_clip;
    if (!g.last) return 1'b0;
    run_sum = '0;
    run_clip = 1'b0;
    return 1'b1;
  endfunction

  // Builds one row of the directed table.
  function automatic dir_row_t vec_row(input act_t a0, input act_t a1, input act_t a2,
                                       input act_t a3, input wt_t w0, input wt_t w1,
                                       input wt_t w2, input wt_t w3, input int lanes,
                                       input logic last, input exp_src_t src,
                                       input longint sum, input logic sat);
    dir_row_t d;
    d.grp.act = {a3, a2, a1, a0};
    d.grp.wt = {w3, w2, w1, w0};
    d.grp.lanes = cnt_t'(lanes);
    d.grp.last = last;
    d.src = src;
    d.want_sum = acc_t'(sum);
    d.want_sat = sat;
    return d;
  endfunction

  // Activations lean on the extremes and on small values around zero.
  function automatic act_t rand_act();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: begin
        return ACT_MAX;
      end
      1: begin
        return ACT_MIN;
      end
      2: begin
        return act_t'($urandom_range(0, 8) - 4);
      end
      3, 4, 5: begin
        return act_t'($urandom_range(0, 2047) - 1024);
      end
      default: begin
        return act_t'($urandom());
      end
    endcase
  endfunction

  // Random group; lane counts outside 1..4 come up now and then.
  function automatic lane_group_t rand_group(input logic last);
    lane_group_t g;
    for (int i = 0; i < LANES; i++) begin
      g.act[i] = rand_act();
      g.wt[i] = wt_t'($urandom_range(0, 3));
    end
    if ($urandom_range(0, 99) < 80) begin
      g.lanes = cnt_t'($urandom_range(1, 4));
    end else begin
      g.lanes = cnt_t'($urandom_range(0, 7));
    end
    g.last = last;
    return g;
  endfunction

  // Gap before the next input beat: mostly none, some short, a few long.
  function automatic int src_gap();
    int r;
    if (!src_idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drives one input beat, waits for the handshake, then records what it should produce.
  task automatic send_group(input lane_group_t g, input exp_src_t src = BY_MODEL,
                            input acc_t want_sum = '0, input logic want_sat = 1'b0);
    int          gap;
    dot_result_t r;
    gap = src_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.act0 <= g.act[0];
    in_ch.act1 <= g.act[1];
    in_ch.act2 <= g.act[2];
    in_ch.act3 <= g.act[3];
    in_ch.wt0 <= g.wt[0];
    in_ch.wt1 <= g.wt[1];
    in_ch.wt2 <= g.wt[2];
    in_ch.wt3 <= g.wt[3];
    in_ch.valid_lanes <= g.lanes;
    in_ch.last_item <= g.last;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (accumulate_group(g, r)) begin
      if (src == BY_TABLE) begin
        r.dot_sum = want_sum;
        r.saturated = want_sat;
      end
      expected_sums.push_back(r);
    end
  endtask

  // Compares one result beat with the oldest expected sum.
  task automatic check_result();
    dot_result_t want;
    if (expected_sums.size() == 0) begin
      report_mismatch($sformatf("result beat with nothing expected: sum=%0d sat=%0b",
                                out_ch.dot_sum, out_ch.saturated));
    end else begin
      want = expected_sums.pop_front();
      if (out_ch.dot_sum !== want.dot_sum) begin
        report_mismatch($sformatf("dot_sum %0d, expected %0d", out_ch.dot_sum, want.dot_sum));
      end
      if (out_ch.saturated !== want.saturated) begin
        report_mismatch($sformatf("saturated %0b, expected %0b", out_ch.saturated,
                                  want.saturated));
      end
    end
  endtask

  // Result side: checks every accepted beat and stalls in random stretches.
  initial begin : result_sink
    int  stall_left;
    int  mode_left;
    bit  stalls_on;
    int  r;
    stall_left = 0;
    mode_left = 0;
    stalls_on = 1'b1;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ch.ready <= 1'b0;
      end else begin
        if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) check_result();
        if (mode_left == 0) begin
          mode_left = $urandom_range(50, 400);
          stalls_on = ($urandom_range(0, 3) != 0);
        end else begin
          mode_left--;
        end
        r = $urandom_range(0, 99);
        if (stall_left > 0) begin
          stall_left--;
          out_ch.ready <= 1'b0;
        end else if (stalls_on && r >= 70) begin
          stall_left = (r < 96) ? $urandom_range(0, 2) : $urandom_range(8, 40);
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Ends the run if neither channel moves a beat for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Stimulus: directed table, then random runs.
  initial begin : stimulus
    int sent;
    int run_len;
    mismatches = 0;
    run_sum = '0;
    run_clip = 1'b0;
    src_idle_on = 1'b1;
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.act0 <= '0;
    in_ch.act1 <= '0;
    in_ch.act2 <= '0;
    in_ch.act3 <= '0;
    in_ch.wt0 <= '0;
    in_ch.wt1 <= '0;
    in_ch.wt2 <= '0;
    in_ch.wt3 <= '0;
    in_ch.valid_lanes <= '0;
    in_ch.last_item <= 1'b0;

    dir_table = '{
      // All-zero group right after reset.
      vec_row(0, 0, 0, 0, WT_ZERO, WT_ZERO, WT_ZERO, WT_ZERO, 4, 1, BY_TABLE, 0, 0),
      // Activation extremes under both signs.
      vec_row(ACT_MAX, ACT_MAX, ACT_MAX, ACT_MAX, WT_POS, WT_POS, WT_POS, WT_POS, 4, 1,
              BY_TABLE, 131068, 0),
      vec_row(ACT_MIN, ACT_MIN, ACT_MIN, ACT_MIN, WT_POS, WT_POS, WT_POS, WT_POS, 4, 1,
              BY_TABLE, -131072, 0),
      vec_row(ACT_MIN, ACT_MIN, ACT_MIN, ACT_MIN, WT_NEG, WT_NEG, WT_NEG, WT_NEG, 4, 1,
              BY_TABLE, 131072, 0),
      vec_row(ACT_MAX, ACT_MAX, ACT_MAX, ACT_MAX, WT_NEG, WT_NEG, WT_NEG, WT_NEG, 4, 1,
              BY_TABLE, -131068, 0),
      // The unused weight code contributes nothing.
      vec_row(ACT_MAX, ACT_MAX, ACT_MAX, ACT_MAX, WT_SKIP, WT_SKIP, WT_SKIP, WT_SKIP, 4, 1,
              BY_TABLE, 0, 0),
      // Zero lanes, and lane counts above the lane total.
      vec_row(ACT_MAX, ACT_MAX, ACT_MAX, ACT_MAX, WT_POS, WT_POS, WT_POS, WT_POS, 0, 1,
              BY_TABLE, 0, 0),
      vec_row(ACT_MAX, ACT_MAX, ACT_MAX, ACT_MAX, WT_POS, WT_POS, WT_POS, WT_POS, 7, 1,
              BY_TABLE, 131068, 0),
      vec_row(ACT_MIN, ACT_MIN, ACT_MIN, ACT_MIN, WT_NEG, WT_NEG, WT_NEG, WT_NEG, 5, 1,
              BY_TABLE, 131072, 0),
      vec_row(ACT_MAX, ACT_MAX, ACT_MAX, ACT_MAX, WT_POS, WT_POS, WT_POS, WT_POS, 6, 1,
              BY_TABLE, 131068, 0),
      // Partial tails.
      vec_row(100, 1000, 1000, 1000, WT_POS, WT_POS, WT_POS, WT_POS, 1, 1, BY_TABLE, 100, 0),
      vec_row(100, 1000, 1000, 1000, WT_POS, WT_POS, WT_POS, WT_POS, 2, 1, BY_TABLE, 1100, 0),
      vec_row(100, 1000, 1000, 1000, WT_POS, WT_POS, WT_POS, WT_POS, 3, 1, BY_TABLE, 2100, 0),
      // Every weight code in one group, then alternating bit patterns under both signs.
      vec_row(1, 2, 3, 4, WT_POS, WT_NEG, WT_ZERO, WT_SKIP, 4, 1, BY_TABLE, -1, 0),
      vec_row(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, WT_POS, WT_NEG, WT_POS, WT_NEG, 4, 1,
              BY_TABLE, 87382, 0),
      // A run of several groups.
      vec_row(256, -256, 512, -512, WT_POS, WT_POS, WT_NEG, WT_NEG, 4, 0, BY_MODEL, 0, 0),
      vec_row(ACT_MAX, ACT_MIN, ACT_MAX, ACT_MIN, WT_NEG, WT_POS, WT_SKIP, WT_ZERO, 3, 0,
              BY_MODEL, 0, 0),
      vec_row(1, 1, 1, 1, WT_POS, WT_POS, WT_POS, WT_POS, 0, 0, BY_MODEL, 0, 0),
      vec_row(-1, -1, -1, -1, WT_NEG, WT_NEG, WT_NEG, WT_NEG, 4, 1, BY_MODEL, 0, 0),
      // A last group with zero lanes still emits the running sum.
      vec_row(ACT_MAX, ACT_MAX, ACT_MAX, ACT_MAX, WT_POS, WT_POS, WT_POS, WT_POS, 4, 0,
              BY_MODEL, 0, 0),
      vec_row(ACT_MIN, ACT_MIN, ACT_MIN, ACT_MIN, WT_POS, WT_POS, WT_POS, WT_POS, 0, 1,
              BY_TABLE, 131068, 0),
      vec_row(16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, WT_SKIP, WT_ZERO, WT_NEG, WT_POS, 4,
              1, BY_MODEL, 0, 0)
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed table.
    foreach (dir_table[i]) begin
      send_group(dir_table[i].grp, dir_table[i].src, dir_table[i].want_sum,
                 dir_table[i].want_sat);
    end

    // Random runs of groups, each closed by a last beat.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      run_len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
      src_idle_on = ($urandom_range(0, 4) != 0);
      for (int k = 0; k < run_len; k++) send_group(rand_group(k == run_len - 1));
      sent += run_len;
    end
    in_ch.valid <= 1'b0;

    // Wait out every owed sum, then keep watching for stray beats.
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
